// ===== rtl/circle_point_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Circle point generator assertion macros
// Shared concurrent assertion forms for the circle point generator checks.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_POINT_GENERATOR_DEFINES_SVH
`define CIRCLE_POINT_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circle_point_generator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circle_point_generator: next-cycle check failed");

`endif

// ===== rtl/cpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle point generator package
// Widths, codes and shared types of the circle point generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpg_pkg;

  // Default field widths.
  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  localparam int POINT_BITS  = 14;

  // Step records held between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Eight mirrored points per step.
  localparam int STEP_POINTS = 8;
  localparam int IDX_W       = $clog2(STEP_POINTS);
  typedef logic [IDX_W-1:0] point_idx_t;
  localparam point_idx_t LAST_POINT = point_idx_t'(STEP_POINTS - 1);

  // Input action codes.
  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic nonempty;
  } cpg_q_status_t;

endpackage

`default_nettype wire

// ===== rtl/cpg_queue.sv =====
// ----------------------------------------------------------------------------
// Step record queue
// Short register FIFO that decouples the step front from the point back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cpg_pkg::QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [WIDTH-1:0]      wr_data,
  input  wire logic                  pop,
  output logic      [WIDTH-1:0]      rd_data,
  output cpg_pkg::cpg_q_status_t     status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Status and head of the queue.
  always_comb begin
    status.full     = (count == CNT_W'(DEPTH));
    status.nonempty = (count != '0);
    rd_data         = mem[rd_ptr];
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cpg_front.sv =====
// ----------------------------------------------------------------------------
// Circle step front end
// Accepts items, holds the circle state and runs the three-branch error rule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_front #(
  parameter int COORD_BITS  = cpg_pkg::COORD_BITS,
  parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS,
  localparam int REC_W      = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   action,
  input  wire logic [COORD_BITS-1:0]  center_x,
  input  wire logic [COORD_BITS-1:0]  center_y,
  input  wire logic [RADIUS_BITS-1:0] radius,
  input  wire cpg_pkg::cpg_q_status_t q_status,
  output logic                        push,
  output logic [REC_W-1:0]            rec
);

  localparam int OFF_W = RADIUS_BITS + 2;
  localparam int D_W   = RADIUS_BITS + 4;

  // Circle state.
  logic                   active;
  logic [COORD_BITS-1:0]  held_cx;
  logic [COORD_BITS-1:0]  held_cy;
  logic [RADIUS_BITS-1:0] held_r;
  logic signed [OFF_W-1:0] ox;
  logic signed [OFF_W-1:0] oy;
  logic signed [D_W-1:0]   d;

  logic                    accept;
  logic                    is_start;
  logic                    emit;
  logic [COORD_BITS-1:0]   cur_cx;
  logic [COORD_BITS-1:0]   cur_cy;
  logic [RADIUS_BITS-1:0]  cur_r;
  logic signed [OFF_W-1:0] cur_ox;
  logic signed [OFF_W-1:0] cur_oy;
  logic signed [D_W-1:0]   cur_d;
  logic signed [D_W-1:0]   rad_d;
  logic signed [D_W-1:0]   r_d;
  logic signed [D_W-1:0]   ox_d;
  logic signed [D_W-1:0]   oy_d;
  logic signed [D_W-1:0]   two_ox;
  logic signed [D_W-1:0]   two_rmy;
  logic signed [OFF_W-1:0] ox_next;
  logic signed [OFF_W-1:0] oy_next;
  logic signed [D_W-1:0]   d_next;
  logic                    done_next;

  // Select the step operands: fresh ones on start, held ones on advance.
  always_comb begin
    accept   = in_valid && !in_stall;
    is_start = (action == cpg_pkg::ACT_START);
    emit     = is_start || active;
    rad_d    = signed'({4'b0000, radius});
    cur_cx   = is_start ? center_x : held_cx;
    cur_cy   = is_start ? center_y : held_cy;
    cur_r    = is_start ? radius : held_r;
    cur_ox   = is_start ? '0 : ox;
    cur_oy   = is_start ? signed'({2'b00, radius}) : oy;
    cur_d    = is_start ? rad_d - D_W'(1) : d;
  end

  // Three-branch error rule for the next offsets.
  always_comb begin
    r_d     = signed'({4'b0000, cur_r});
    ox_d    = D_W'(cur_ox);
    oy_d    = D_W'(cur_oy);
    two_ox  = ox_d <<< 1;
    two_rmy = (r_d - oy_d) <<< 1;
    if (cur_d >= two_ox) begin
      d_next  = cur_d - two_ox - D_W'(1);
      ox_next = cur_ox + OFF_W'(1);
      oy_next = cur_oy;
    end else if (cur_d < two_rmy) begin
      d_next  = cur_d + (oy_d <<< 1) - D_W'(1);
      ox_next = cur_ox;
      oy_next = cur_oy - OFF_W'(1);
    end else begin
      d_next  = cur_d + ((oy_d - ox_d - D_W'(1)) <<< 1);
      ox_next = cur_ox + OFF_W'(1);
      oy_next = cur_oy - OFF_W'(1);
    end
    done_next = (oy_next < ox_next);
  end

  // Emitted offsets are never negative and never exceed the radius.
  always_comb begin
    in_stall = q_status.full;
    push     = accept && emit;
    rec      = {cur_cx, cur_cy, cur_ox[RADIUS_BITS-1:0], cur_oy[RADIUS_BITS-1:0], done_next};
  end

  // Active flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (push) begin
      active <= !done_next;
    end
  end

  // Held circle state, updated on every step-producing transfer.
  always_ff @(posedge clk) begin
    if (push) begin
      held_cx <= cur_cx;
      held_cy <= cur_cy;
      held_r  <= cur_r;
      ox      <= ox_next;
      oy      <= oy_next;
      d       <= d_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cpg_back.sv =====
// ----------------------------------------------------------------------------
// Circle point back end
// Expands each step record into eight mirrored points, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_back #(
  parameter int COORD_BITS  = cpg_pkg::COORD_BITS,
  parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS,
  localparam int REC_W      = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire cpg_pkg::cpg_q_status_t             q_status,
  input  wire logic [REC_W-1:0]                   rd_data,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [cpg_pkg::POINT_BITS-1:0]   point_x,
  output logic signed [cpg_pkg::POINT_BITS-1:0]   point_y,
  output logic                                    last_of_step,
  output logic                                    circle_done
);

  localparam int BASE_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam int SUM_W  = (BASE_W > cpg_pkg::POINT_BITS) ? BASE_W : cpg_pkg::POINT_BITS;

  // Step being expanded.
  logic                   busy;
  cpg_pkg::point_idx_t    k;
  logic [COORD_BITS-1:0]  cur_cx;
  logic [COORD_BITS-1:0]  cur_cy;
  logic [RADIUS_BITS-1:0] cur_ox;
  logic [RADIUS_BITS-1:0] cur_oy;
  logic                   cur_done;

  logic                   load;
  logic                   last_k;
  logic [RADIUS_BITS-1:0] mag_x;
  logic [RADIUS_BITS-1:0] mag_y;
  logic signed [SUM_W-1:0] cx_s;
  logic signed [SUM_W-1:0] cy_s;
  logic signed [SUM_W-1:0] mx_s;
  logic signed [SUM_W-1:0] my_s;
  logic signed [SUM_W-1:0] px;
  logic signed [SUM_W-1:0] py;

  // Load a point when the output register is free; take the next record
  // as the current step hands over its eighth point.
  always_comb begin
    load   = busy && (!out_valid || !out_stall);
    last_k = (k == cpg_pkg::LAST_POINT);
    pop    = q_status.nonempty && (!busy || (load && last_k));
  end

  // Mirror select: bit 0 swaps the offsets, bit 1 negates x, bit 2 negates y.
  always_comb begin
    mag_x = k[0] ? cur_oy : cur_ox;
    mag_y = k[0] ? cur_ox : cur_oy;
    cx_s  = signed'(SUM_W'(cur_cx));
    cy_s  = signed'(SUM_W'(cur_cy));
    mx_s  = signed'(SUM_W'(mag_x));
    my_s  = signed'(SUM_W'(mag_y));
    px    = k[1] ? cx_s - mx_s : cx_s + mx_s;
    py    = k[2] ? cy_s - my_s : cy_s + my_s;
  end

  // Control: step sequencing and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (load && last_k) begin
        busy <= 1'b0;
      end else if (load) begin
        k <= k + 1'b1;
      end
    end
  end

  // Current step record.
  always_ff @(posedge clk) begin
    if (pop) begin
      {cur_cx, cur_cy, cur_ox, cur_oy, cur_done} <= rd_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      point_x      <= px[cpg_pkg::POINT_BITS-1:0];
      point_y      <= py[cpg_pkg::POINT_BITS-1:0];
      last_of_step <= last_k;
      circle_done  <= last_k && cur_done;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/circle_point_generator.sv =====
// ----------------------------------------------------------------------------
// Circle point generator
// Integer circle rasterizer with the Andres three-branch error rule.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): action, center_x, center_y, radius.
//   A start transfer loads a circle and produces its first step; an advance
//   transfer produces the next step of the running circle, or nothing when
//   no circle is active.
//   Output channel (out_valid / out_stall): point_x, point_y, last_of_step,
//   circle_done. Each step gives eight mirrored points; last_of_step marks
//   the eighth, circle_done marks the eighth point of the final step.
//   The first point of a step passes from the step queue through the current
//   step record register to the output register. The single output register
//   shows one point per cycle while out_stall is low. A two-entry step queue
//   lets the front take input transfers while the back is still emitting
//   points.
//   Reset (rst, synchronous) empties the queue and output and makes the
//   block idle. While out_stall is high the current point holds and
//   in_stall rises once the step queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circle_point_generator #(
  parameter int COORD_BITS  = cpg_pkg::COORD_BITS,
  parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             action,
  input  wire logic [COORD_BITS-1:0]            center_x,
  input  wire logic [COORD_BITS-1:0]            center_y,
  input  wire logic [RADIUS_BITS-1:0]           radius,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [cpg_pkg::POINT_BITS-1:0] point_x,
  output logic signed [cpg_pkg::POINT_BITS-1:0] point_y,
  output logic                                  last_of_step,
  output logic                                  circle_done
);

  localparam int REC_W = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

  cpg_pkg::cpg_q_status_t q_status;
  logic                   push;
  logic                   pop;
  logic [REC_W-1:0]       wr_rec;
  logic [REC_W-1:0]       rd_rec;

  // Front: accepts transfers and computes steps.
  cpg_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .q_status (q_status),
    .push     (push),
    .rec      (wr_rec)
  );

  // Step queue between front and back.
  cpg_queue #(
    .WIDTH (REC_W),
    .DEPTH (cpg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_rec),
    .pop     (pop),
    .rd_data (rd_rec),
    .status  (q_status)
  );

  // Back: expands steps into points.
  cpg_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .rd_data      (rd_rec),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule

`default_nettype wire

// ===== rtl/cpg_checker.sv =====
// ----------------------------------------------------------------------------
// Circle point generator checker
// Port-level assertions on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "circle_point_generator_defines.svh"

module cpg_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [cpg_pkg::POINT_BITS-1:0]   point_x,
  input wire logic [cpg_pkg::POINT_BITS-1:0]   point_y,
  input wire logic                             last_of_step,
  input wire logic                             circle_done
);

  // A stalled point stays valid and unchanged.
  `CPG_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(point_x) && $stable(point_y))

  // The end of a circle is always the end of a step.
  `CPG_ASSERT_SAME(a_done_is_last, out_valid && circle_done, last_of_step)

  // The eight points of a step follow each other without a gap.
  `CPG_ASSERT_NEXT(a_step_no_gap, out_valid && !out_stall && !last_of_step, out_valid)

endmodule

bind circle_point_generator cpg_checker u_cpg_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Circle point generator testbench
// Drives start and advance transfers into the rasterizer and checks every
// plotted point against a cycle-free model of the Andres circle rule. A short
// table of directed rows (idle advances, zero radius, extreme centers and
// radii, abandoned circles) runs first. Random circles follow, most of them
// small and run to completion. Random gaps and stalls are placed on both
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // Local names for the package widths and codes.
  localparam int COORD_BITS  = cpg_pkg::COORD_BITS;
  localparam int RADIUS_BITS = cpg_pkg::RADIUS_BITS;
  localparam int POINT_BITS  = cpg_pkg::POINT_BITS;
  localparam int STEP_POINTS = cpg_pkg::STEP_POINTS;
  typedef cpg_pkg::action_t action_t;
  localparam action_t ACT_START   = cpg_pkg::ACT_START;
  localparam action_t ACT_ADVANCE = cpg_pkg::ACT_ADVANCE;

  localparam int RANDOM_ITEMS = 150;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 16;

  // One plotted point as it leaves the block.
  typedef struct {
    logic signed [POINT_BITS-1:0] x;
    logic signed [POINT_BITS-1:0] y;
    logic                         last;
    logic                         done;
  } point_t;

  // One row of the directed table. Where typed is set, the first point of
  // the step and the done flag of its last point are given by hand.
  typedef struct {
    action_t                act;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] r;
    bit                     typed;
    int                     tx;
    int                     ty;
    bit                     tdone;
  } stim_row_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic                         action;
  logic [COORD_BITS-1:0]        center_x;
  logic [COORD_BITS-1:0]        center_y;
  logic [RADIUS_BITS-1:0]       radius;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [POINT_BITS-1:0] point_x;
  logic signed [POINT_BITS-1:0] point_y;
  logic                         last_of_step;
  logic                         circle_done;

  circle_point_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Circle state mirrored from the block.
  bit circ_active;
  int circ_cx;
  int circ_cy;
  int circ_r;
  int off_x;
  int off_y;
  int err_d;

  point_t    pending_points[$];
  stim_row_t directed_rows[$];
  point_t    want;

  int errors;
  int items_sent;
  int idle_advances;
  int circles_started;
  int circles_finished;
  int points_checked;
  int idle_cycles;
  int in_calm;
  int out_calm;

  // Gap length: mostly short, a few long, with occasional calm stretches.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 40);
      return 0;
    end
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Emit the eight mirrored points of the current offsets, then advance.
  task automatic plot_step(input bit typed, input int tx, input int ty, input bit tdone);
    int     px[8];
    int     py[8];
    bit     fin;
    point_t p;
    px[0] = circ_cx + off_x; py[0] = circ_cy + off_y;
    px[1] = circ_cx + off_y; py[1] = circ_cy + off_x;
    px[2] = circ_cx - off_x; py[2] = circ_cy + off_y;
    px[3] = circ_cx - off_y; py[3] = circ_cy + off_x;
    px[4] = circ_cx + off_x; py[4] = circ_cy - off_y;
    px[5] = circ_cx + off_y; py[5] = circ_cy - off_x;
    px[6] = circ_cx - off_x; py[6] = circ_cy - off_y;
    px[7] = circ_cx - off_y; py[7] = circ_cy - off_x;
    // Three-branch error update.
    if (err_d >= 2 * off_x) begin
      err_d = err_d - (2 * off_x + 1);
      off_x = off_x + 1;
    end else if (err_d < 2 * (circ_r - off_y)) begin
      err_d = err_d + (2 * off_y - 1);
      off_y = off_y - 1;
    end else begin
      err_d = err_d + 2 * (off_y - off_x - 1);
      off_y = off_y - 1;
      off_x = off_x + 1;
    end
    fin = (off_y < off_x);
    if (fin) begin
      circ_active = 1'b0;
      circles_finished++;
    end
    if (typed) begin
      px[0] = tx;
      py[0] = ty;
    end
    for (int k = 0; k < STEP_POINTS; k++) begin
      p.x    = px[k][POINT_BITS-1:0];
      p.y    = py[k][POINT_BITS-1:0];
      p.last = (k == STEP_POINTS - 1);
      p.done = (k == STEP_POINTS - 1) && (typed ? tdone : fin);
      pending_points.push_back(p);
    end
  endtask

  // Update the mirrored state for one accepted input transfer.
  task automatic apply_item(input stim_row_t row, output bit produced);
    produced = 1'b0;
    if (row.act == ACT_START) begin
      circ_cx     = int'(row.cx);
      circ_cy     = int'(row.cy);
      circ_r      = int'(row.r);
      off_x       = 0;
      off_y       = circ_r;
      err_d       = circ_r - 1;
      circ_active = 1'b1;
      circles_started++;
      produced = 1'b1;
      plot_step(row.typed, row.tx, row.ty, row.tdone);
    end else if (circ_active) begin
      produced = 1'b1;
      plot_step(row.typed, row.tx, row.ty, row.tdone);
    end else begin
      idle_advances++;
    end
  endtask

  // Present one item after a random gap and wait for its transfer.
  task automatic send_item(input stim_row_t row, output bit produced);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= row.act;
    center_x <= row.cx;
    center_y <= row.cy;
    radius   <= row.r;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
    apply_item(row, produced);
  endtask

  task automatic add_row(input action_t act, input int cx, input int cy, input int r,
                         input bit typed, input int tx, input int ty, input bit tdone);
    stim_row_t row;
    row.act   = act;
    row.cx    = cx[COORD_BITS-1:0];
    row.cy    = cy[COORD_BITS-1:0];
    row.r     = r[RADIUS_BITS-1:0];
    row.typed = typed;
    row.tx    = tx;
    row.ty    = ty;
    row.tdone = tdone;
    directed_rows.push_back(row);
  endtask

  function automatic stim_row_t random_row(input action_t act, input int r);
    stim_row_t row;
    row.act   = act;
    row.cx    = COORD_BITS'($urandom);
    row.cy    = COORD_BITS'($urandom);
    row.r     = r[RADIUS_BITS-1:0];
    row.typed = 1'b0;
    row.tx    = 0;
    row.ty    = 0;
    row.tdone = 1'b0;
    return row;
  endfunction

  // Receiver: random stall stretches between short runs of readiness.
  initial begin
    int gap;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      gap = pick_gap(out_calm);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every point transfer with the oldest expected point.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point: x=%0d y=%0d last=%0b done=%0b",
               point_x, point_y, last_of_step, circle_done);
        errors++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, point_x);
          errors++;
        end
        if (point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, point_y);
          errors++;
        end
        if (last_of_step !== want.last) begin
          $error("last_of_step: expected %0b, got %0b", want.last, last_of_step);
          errors++;
        end
        if (circle_done !== want.done) begin
          $error("circle_done: expected %0b, got %0b", want.done, circle_done);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main stimulus.
  initial begin
    bit        produced;
    int        made;
    int        roll;
    int        r;
    int        steps;
    stim_row_t row;
    errors           = 0;
    items_sent       = 0;
    idle_advances    = 0;
    circles_started  = 0;
    circles_finished = 0;
    points_checked   = 0;
    in_calm          = 0;
    out_calm         = 0;
    circ_active      = 1'b0;
    circ_cx          = 0;
    circ_cy          = 0;
    circ_r           = 0;
    off_x            = 0;
    off_y            = 0;
    err_d            = 0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    action   <= ACT_ADVANCE;
    center_x <= '0;
    center_y <= '0;
    radius   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: idle advances, zero radius, extremes, abandoned circles.
    add_row(ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(ACT_START, 0, 0, 0, 1'b1, 0, 0, 1'b1);
    add_row(ACT_ADVANCE, 4095, 4095, 2047, 1'b0, 0, 0, 1'b0);
    add_row(ACT_START, 4095, 4095, 0, 1'b1, 4095, 4095, 1'b1);
    add_row(ACT_START, 4095, 4095, 2047, 1'b1, 4095, 6142, 1'b0);
    add_row(ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(ACT_START, 0, 0, 2047, 1'b1, 0, 2047, 1'b0);
    add_row(ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(ACT_ADVANCE, 4095, 4095, 2047, 1'b0, 0, 0, 1'b0);
    add_row(ACT_START, 2048, 1365, 1, 1'b1, 2048, 1366, 1'b0);
    add_row(ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(ACT_START, 2730, 1365, 1365, 1'b1, 2730, 2730, 1'b0);
    add_row(ACT_ADVANCE, 1365, 2730, 682, 1'b0, 0, 0, 1'b0);
    add_row(ACT_START, 100, 200, 5, 1'b1, 100, 205, 1'b0);
    for (int k = 0; k < 6; k++) add_row(ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(ACT_START, 3, 4000, 3, 1'b0, 0, 0, 1'b0);
    for (int k = 0; k < 3; k++) add_row(ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    foreach (directed_rows[i]) send_item(directed_rows[i], produced);

    // Random circles: mostly small ones run to the end, some abandoned.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // Noise: an item with a random action.
        row = random_row(action_t'($urandom_range(0, 1)), $urandom);
        send_item(row, produced);
        if (produced) made++;
      end else begin
        if (roll < 70) r = $urandom_range(0, 12);
        else if (roll < 90) r = $urandom_range(13, 60);
        else r = $urandom;
        send_item(random_row(ACT_START, r), produced);
        made++;
        steps = (roll >= 90) ? $urandom_range(0, 4) : 4000;
        while (circ_active && steps > 0 && made < RANDOM_ITEMS) begin
          if ($urandom_range(0, 99) < 3) break;
          send_item(random_row(ACT_ADVANCE, $urandom), produced);
          made++;
          steps--;
        end
        if (!circ_active && $urandom_range(0, 99) < 20) begin
          send_item(random_row(ACT_ADVANCE, $urandom), produced);
        end
      end
    end
    in_valid <= 1'b0;

    // Drain the expected points, then wait out the drain period and check that none are left.
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_points.size() != 0) begin
      $error("%0d expected points never arrived", pending_points.size());
      errors++;
    end

    $display("Sent %0d items (%0d advances while idle), started %0d circles, finished %0d.",
             items_sent, idle_advances, circles_started, circles_finished);
    $display("Checked %0d plotted points; %0d mismatches.", points_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
